// File: rtl/ecpsm_pkg.sv
// Shared types and constants for the point scalar multiply core.
// No dependencies.
package ecpsm_pkg;
	localparam int FieldBits = 16;
	localparam int ScalarBits = 16;
	localparam int ProdBits = 2 * FieldBits;
	localparam logic [FieldBits-1:0] PrimeReset = FieldBits'(1223);
	localparam logic [FieldBits-1:0] CoeffReset = FieldBits'(439);
	localparam logic CfgPrime = 1'b0;
	localparam logic CfgCoeff = 1'b1;

	typedef logic [FieldBits-1:0] felem_t;

	// datapath micro-operations
	typedef enum logic [3:0] {
		OP_NOP,
		OP_MUL,     // r = a*b mod m
		OP_ADD,     // r = a+b mod m
		OP_SUB,     // r = a-b mod m
		OP_RED,     // r = a mod m
		OP_INV      // r = a^-1 mod m, 0 if none
	} dp_op_t;

	typedef struct packed {
		logic       start;
		dp_op_t     op;
		felem_t     a;
		felem_t     b;
	} dp_cmd_t;

	typedef struct packed {
		logic   busy;
		logic   done;
		felem_t r;
	} dp_stat_t;
endpackage

// File: rtl/ecpsm_datapath.sv
// Modular arithmetic unit: multiply, add, subtract, reduce, inverse.
// Depends on ecpsm_pkg. Reduction and inversion are bit-serial.
module ecpsm_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  ecpsm_pkg::felem_t  m,
	input  ecpsm_pkg::dp_cmd_t cmd,
	output ecpsm_pkg::dp_stat_t stat
);
	import ecpsm_pkg::*;

	localparam logic [2:0] D_IDLE = 3'd0;
	localparam logic [2:0] D_MOD  = 3'd1;
	localparam logic [2:0] D_DIV  = 3'd2;
	localparam logic [2:0] D_INVT = 3'd3;
	localparam logic [2:0] D_FIX  = 3'd4;
	localparam logic [2:0] D_MUL  = 3'd5;
	localparam logic [2:0] D_QMUL = 3'd6;
	localparam logic [2:0] D_TUPD = 3'd7;

	localparam int CntBits = $clog2(ProdBits + 1);

	logic [2:0]          st_q;
	logic                done_q;
	felem_t              res_q;
	logic [ProdBits-1:0] rem_q;
	logic [ProdBits-1:0] num_q;
	logic [CntBits-1:0]  cnt_q;
	logic                inv_q;
	felem_t              mul_a_q, mul_b_q;
	// extended Euclid state
	logic [FieldBits:0]  r0_q, r1_q;
	logic signed [FieldBits+1:0] t0_q, t1_q;
	felem_t              quo_q;
	logic [FieldBits:0]  dr_q;
	logic signed [FieldBits+1:0] tprod_q;

	logic [ProdBits:0]   trial;
	logic [FieldBits+1:0] dtrial;
	logic [FieldBits:0]  sum;
	logic signed [FieldBits+1:0] tadj;
	logic signed [ProdBits+2:0] qt;

	assign trial = {rem_q, num_q[ProdBits-1]} - {{(FieldBits+1){1'b0}}, m};
	assign dtrial = {dr_q, r0_q[FieldBits]} - {1'b0, r1_q};
	assign sum = {1'b0, cmd.a} + {1'b0, cmd.b};
	assign tadj = t0_q + $signed({2'b00, m});
	assign qt = $signed({3'b000, quo_q}) * t1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= D_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				D_IDLE: begin
					if (cmd.start) begin
						unique case (cmd.op)
							OP_MUL: begin
								mul_a_q <= cmd.a;
								mul_b_q <= cmd.b;
								inv_q <= 1'b0;
								st_q <= D_MUL;
							end
							OP_ADD: begin
								num_q <= {{(FieldBits-1){1'b0}}, sum};
								rem_q <= '0;
								cnt_q <= CntBits'(ProdBits);
								inv_q <= 1'b0;
								st_q <= D_MOD;
							end
							OP_SUB: begin
								num_q <= ProdBits'({1'b0, cmd.a} + {1'b0, m}
									- {1'b0, cmd.b});
								rem_q <= '0;
								cnt_q <= CntBits'(ProdBits);
								inv_q <= 1'b0;
								st_q <= D_MOD;
							end
							OP_RED: begin
								num_q <= ProdBits'(cmd.a);
								rem_q <= '0;
								cnt_q <= CntBits'(ProdBits);
								inv_q <= 1'b0;
								st_q <= D_MOD;
							end
							OP_INV: begin
								num_q <= ProdBits'(cmd.a);
								rem_q <= '0;
								cnt_q <= CntBits'(ProdBits);
								inv_q <= 1'b1;
								st_q <= D_MOD;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				D_MUL: begin
					num_q <= mul_a_q * mul_b_q;
					rem_q <= '0;
					cnt_q <= CntBits'(ProdBits);
					st_q <= D_MOD;
				end
				D_MOD: begin
					if (!trial[ProdBits])
						rem_q <= trial[ProdBits-1:0];
					else
						rem_q <= {rem_q[ProdBits-2:0], num_q[ProdBits-1]};
					num_q <= {num_q[ProdBits-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CntBits'(1)) begin
						if (inv_q) begin
							r0_q <= {1'b0, m};
							r1_q <= !trial[ProdBits] ? trial[FieldBits:0]
								: {rem_q[FieldBits-1:0], num_q[ProdBits-1]};
							t0_q <= '0;
							t1_q <= (FieldBits+2)'(1);
							st_q <= D_INVT;
						end else begin
							res_q <= !trial[ProdBits] ? trial[FieldBits-1:0]
								: {rem_q[FieldBits-2:0], num_q[ProdBits-1]};
							done_q <= 1'b1;
							st_q <= D_IDLE;
						end
					end
				end
				D_INVT: begin
					if (r1_q == '0) begin
						st_q <= D_FIX;
					end else begin
						dr_q <= '0;
						quo_q <= '0;
						cnt_q <= CntBits'(FieldBits + 1);
						st_q <= D_DIV;
					end
				end
				D_DIV: begin
					// restoring division r0 / r1
					if (!dtrial[FieldBits+1]) begin
						dr_q <= dtrial[FieldBits:0];
						quo_q <= {quo_q[FieldBits-2:0], 1'b1};
					end else begin
						dr_q <= {dr_q[FieldBits-1:0], r0_q[FieldBits]};
						quo_q <= {quo_q[FieldBits-2:0], 1'b0};
					end
					r0_q <= {r0_q[FieldBits-1:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CntBits'(1)) begin
						r0_q <= r1_q;
						r1_q <= !dtrial[FieldBits+1] ? dtrial[FieldBits:0]
							: {dr_q[FieldBits-1:0], r0_q[FieldBits]};
						st_q <= D_QMUL;
					end
				end
				D_QMUL: begin
					tprod_q <= (FieldBits+2)'(qt);
					st_q <= D_TUPD;
				end
				D_TUPD: begin
					t0_q <= t1_q;
					t1_q <= t0_q - tprod_q;
					st_q <= D_INVT;
				end
				D_FIX: begin
					if (r0_q != (FieldBits+1)'(1))
						res_q <= '0;
					else if (t0_q < 0)
						res_q <= tadj[FieldBits-1:0];
					else
						res_q <= t0_q[FieldBits-1:0];
					done_q <= 1'b1;
					st_q <= D_IDLE;
				end
				default: st_q <= D_IDLE;
			endcase
		end
	end

	assign stat.busy = (st_q != D_IDLE);
	assign stat.done = done_q;
	assign stat.r = res_q;
endmodule

// File: rtl/ecpsm_ctrl.sv
// Sequencer for double-and-add over the scalar bits.
// Depends on ecpsm_pkg; drives ecpsm_datapath through command/status.
module ecpsm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ecpsm_pkg::felem_t   m,
	input  ecpsm_pkg::felem_t   coef,
	input  ecpsm_pkg::felem_t   px,
	input  ecpsm_pkg::felem_t   py,
	input  logic [ecpsm_pkg::ScalarBits-1:0] k,
	input  ecpsm_pkg::dp_stat_t stat,
	output ecpsm_pkg::dp_cmd_t  cmd,
	output logic                busy,
	output logic                fin,
	output ecpsm_pkg::felem_t   rx,
	output ecpsm_pkg::felem_t   ry
);
	import ecpsm_pkg::*;

	// micro-program steps
	localparam logic [5:0] S_IDLE  = 6'd0;
	localparam logic [5:0] S_RA    = 6'd1;
	localparam logic [5:0] S_RX    = 6'd2;
	localparam logic [5:0] S_RY    = 6'd3;
	localparam logic [5:0] S_LOOP  = 6'd4;
	localparam logic [5:0] S_PADD  = 6'd5;  // begin point op
	localparam logic [5:0] S_A1    = 6'd6;  // dy = qy-py
	localparam logic [5:0] S_A2    = 6'd7;  // dx = qx-px
	localparam logic [5:0] S_A3    = 6'd8;  // inv dx
	localparam logic [5:0] S_A4    = 6'd9;  // lam = dy*inv
	localparam logic [5:0] S_D1    = 6'd10; // x^2
	localparam logic [5:0] S_D2    = 6'd11; // 2x^2
	localparam logic [5:0] S_D3    = 6'd12; // 3x^2
	localparam logic [5:0] S_D4    = 6'd13; // +a
	localparam logic [5:0] S_D5    = 6'd14; // 2y
	localparam logic [5:0] S_D6    = 6'd15; // inv
	localparam logic [5:0] S_D7    = 6'd16; // lam
	localparam logic [5:0] S_D8    = 6'd17; // 2x
	localparam logic [5:0] S_X1    = 6'd18; // lam^2
	localparam logic [5:0] S_X2    = 6'd19; // - px (or -2x)
	localparam logic [5:0] S_X3    = 6'd20; // - qx
	localparam logic [5:0] S_Y1    = 6'd21; // px - rx
	localparam logic [5:0] S_Y2    = 6'd22; // lam*()
	localparam logic [5:0] S_Y3    = 6'd23; // - py
	localparam logic [5:0] S_WB    = 6'd24;
	localparam logic [5:0] S_DONE  = 6'd25;

	localparam int IdxBits = $clog2(ScalarBits + 1);

	logic [5:0] st_q, ret_q;
	logic       wait_q;
	logic       dbl_q;        // current op is doubling of add point
	logic       phase_q;      // 0: acc+=add, 1: add=2add
	felem_t     a_q, ax_q, ay_q, cx_q, cy_q;
	felem_t     px_q, py_q, qx_q, qy_q;
	felem_t     lam_q, t_q, u_q, nx_q, ny_q;
	logic [ScalarBits-1:0] k_q;
	logic [IdxBits-1:0]    i_q;
	logic       issue;
	dp_op_t     op;
	felem_t     oa, ob;

	always_comb begin
		issue = 1'b0;
		op = OP_NOP;
		oa = '0;
		ob = '0;
		unique case (st_q)
			S_RA: begin issue = 1'b1; op = OP_RED; oa = coef; end
			S_RX: begin issue = 1'b1; op = OP_RED; oa = ax_q; end
			S_RY: begin issue = 1'b1; op = OP_RED; oa = ay_q; end
			S_A1: begin issue = 1'b1; op = OP_SUB; oa = qy_q; ob = py_q; end
			S_A2: begin issue = 1'b1; op = OP_SUB; oa = qx_q; ob = px_q; end
			S_A3: begin issue = 1'b1; op = OP_INV; oa = u_q; end
			S_A4: begin issue = 1'b1; op = OP_MUL; oa = t_q; ob = u_q; end
			S_D1: begin issue = 1'b1; op = OP_MUL; oa = px_q; ob = px_q; end
			S_D2: begin issue = 1'b1; op = OP_ADD; oa = t_q; ob = t_q; end
			S_D3: begin issue = 1'b1; op = OP_ADD; oa = u_q; ob = t_q; end
			S_D4: begin issue = 1'b1; op = OP_ADD; oa = u_q; ob = a_q; end
			S_D5: begin issue = 1'b1; op = OP_ADD; oa = py_q; ob = py_q; end
			S_D6: begin issue = 1'b1; op = OP_INV; oa = u_q; end
			S_D7: begin issue = 1'b1; op = OP_MUL; oa = t_q; ob = u_q; end
			S_D8: begin issue = 1'b1; op = OP_ADD; oa = px_q; ob = px_q; end
			S_X1: begin issue = 1'b1; op = OP_MUL; oa = lam_q; ob = lam_q; end
			S_X2: begin issue = 1'b1; op = OP_SUB; oa = u_q; ob = dbl_q ? t_q : px_q; end
			S_X3: begin issue = 1'b1; op = OP_SUB; oa = u_q; ob = qx_q; end
			S_Y1: begin issue = 1'b1; op = OP_SUB; oa = px_q; ob = nx_q; end
			S_Y2: begin issue = 1'b1; op = OP_MUL; oa = lam_q; ob = u_q; end
			S_Y3: begin issue = 1'b1; op = OP_SUB; oa = u_q; ob = py_q; end
			default: ;
		endcase
	end

	assign cmd.start = issue && !wait_q;
	assign cmd.op = op;
	assign cmd.a = oa;
	assign cmd.b = ob;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			wait_q <= 1'b0;
			fin <= 1'b0;
		end else begin
			fin <= 1'b0;
			if (issue && !wait_q) begin
				wait_q <= 1'b1;
			end else if (issue && wait_q) begin
				if (stat.done) begin
					wait_q <= 1'b0;
					unique case (st_q)
						S_RA: begin a_q <= stat.r; st_q <= S_RX; end
						S_RX: begin ax_q <= stat.r; st_q <= S_RY; end
						S_RY: begin
							ay_q <= stat.r;
							cx_q <= '0;
							cy_q <= '0;
							i_q <= '0;
							st_q <= S_LOOP;
						end
						S_A1: begin t_q <= stat.r; st_q <= S_A2; end
						S_A2: begin u_q <= stat.r; st_q <= S_A3; end
						S_A3: begin u_q <= stat.r; st_q <= S_A4; end
						S_A4: begin lam_q <= stat.r; st_q <= S_X1; end
						S_D1: begin t_q <= stat.r; st_q <= S_D2; end
						S_D2: begin u_q <= stat.r; st_q <= S_D3; end
						S_D3: begin u_q <= stat.r; st_q <= S_D4; end
						S_D4: begin t_q <= stat.r; st_q <= S_D5; end
						S_D5: begin u_q <= stat.r; st_q <= S_D6; end
						S_D6: begin u_q <= stat.r; st_q <= S_D7; end
						S_D7: begin lam_q <= stat.r; st_q <= S_D8; end
						S_D8: begin t_q <= stat.r; st_q <= S_X1; end
						S_X1: begin u_q <= stat.r; st_q <= S_X2; end
						S_X2: begin
							u_q <= stat.r;
							if (dbl_q) begin
								nx_q <= stat.r;
								st_q <= S_Y1;
							end else begin
								st_q <= S_X3;
							end
						end
						S_X3: begin nx_q <= stat.r; st_q <= S_Y1; end
						S_Y1: begin u_q <= stat.r; st_q <= S_Y2; end
						S_Y2: begin u_q <= stat.r; st_q <= S_Y3; end
						S_Y3: begin ny_q <= stat.r; st_q <= S_WB; end
						default: st_q <= S_IDLE;
					endcase
				end
			end else begin
				unique case (st_q)
					S_IDLE: begin
						if (start) begin
							k_q <= k;
							ax_q <= px;
							ay_q <= py;
							if (m < FieldBits'(3)) begin
								cx_q <= '0;
								cy_q <= '0;
								st_q <= S_DONE;
							end else begin
								st_q <= S_RA;
							end
						end
					end
					S_LOOP: begin
						if (i_q == IdxBits'(ScalarBits) || k_q == '0) begin
							st_q <= S_DONE;
						end else if (k_q[0]) begin
							phase_q <= 1'b0;
							st_q <= S_PADD;
						end else begin
							phase_q <= 1'b1;
							st_q <= S_PADD;
						end
					end
					S_PADD: begin
						// P = first operand, Q = second
						if (!phase_q) begin
							px_q <= cx_q; py_q <= cy_q;
						end else begin
							px_q <= ax_q; py_q <= ay_q;
						end
						qx_q <= ax_q;
						qy_q <= ay_q;
						if (!phase_q && cx_q == '0 && cy_q == '0) begin
							nx_q <= ax_q; ny_q <= ay_q;
							st_q <= S_WB;
						end else if (ax_q == '0 && ay_q == '0) begin
							nx_q <= phase_q ? ax_q : cx_q;
							ny_q <= phase_q ? ay_q : cy_q;
							st_q <= S_WB;
						end else if (phase_q || cx_q == ax_q) begin
							if ((phase_q ? 1'b0 : (cy_q != ay_q)) || ay_q == '0) begin
								nx_q <= '0; ny_q <= '0;
								st_q <= S_WB;
							end else begin
								dbl_q <= 1'b1;
								st_q <= S_D1;
							end
						end else begin
							dbl_q <= 1'b0;
							st_q <= S_A1;
						end
					end
					S_WB: begin
						if (!phase_q) begin
							cx_q <= nx_q; cy_q <= ny_q;
							phase_q <= 1'b1;
							st_q <= S_PADD;
						end else begin
							ax_q <= nx_q; ay_q <= ny_q;
							k_q <= k_q >> 1;
							i_q <= i_q + 1'b1;
							st_q <= S_LOOP;
						end
					end
					S_DONE: begin
						fin <= 1'b1;
						st_q <= S_IDLE;
					end
					default: st_q <= S_IDLE;
				endcase
			end
		end
	end

	assign busy = (st_q != S_IDLE);
	assign rx = cx_q;
	assign ry = cy_q;
endmodule

// File: rtl/ecc_point_scalar_multiply_core.sv
// Point scalar multiply core: a sequencer and a modular arithmetic unit.
// Depends on ecpsm_pkg, ecpsm_ctrl and ecpsm_datapath.
// One transaction at a time. A transaction skips the arithmetic and yields the
// point at infinity when the prime is below three; otherwise its length is set
// by the position of the highest set scalar bit and by the Euclid step counts:
// three input reductions run first, then each bit up to the highest set one runs
// a doubling and, where the bit is set, an addition in the shared arithmetic
// unit. An inverse runs one Euclid step after another (up to about 23 steps)
// after its reduction. A result waits in an output register; input stalls from
// the end of a transaction until that register is free.
module ecc_point_scalar_multiply_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [ecpsm_pkg::FieldBits-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [ecpsm_pkg::FieldBits-1:0]  point_x,
	input  logic [ecpsm_pkg::FieldBits-1:0]  point_y,
	input  logic [ecpsm_pkg::ScalarBits-1:0] scalar,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [ecpsm_pkg::FieldBits-1:0]  result_x,
	output logic [ecpsm_pkg::FieldBits-1:0]  result_y,
	output logic                             at_infinity
);
	import ecpsm_pkg::*;

	felem_t   prime_q, coef_q;
	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     busy, fin, start;
	felem_t   rx, ry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_q <= PrimeReset;
			coef_q <= CoeffReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgPrime: prime_q <= cfg_data;
				CfgCoeff: coef_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = busy || fin || (out_valid && out_stall);
	assign start = in_valid && !in_stall;

	ecpsm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .m(prime_q), .coef(coef_q),
		.px(point_x), .py(point_y), .k(scalar), .stat(stat), .cmd(cmd),
		.busy(busy), .fin(fin), .rx(rx), .ry(ry)
	);

	ecpsm_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .m(prime_q), .cmd(cmd), .stat(stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fin) begin
			out_valid <= 1'b1;
			result_x <= rx;
			result_y <= ry;
			at_infinity <= (rx == '0) && (ry == '0);
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	a_inf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && at_infinity |-> result_x == '0 && result_y == '0)
		else $error("infinity flag with nonzero coordinates");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !start)
		else $error("start while busy");
	a_cmd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> stat.busy || stat.done)
		else $error("arithmetic command lost");
endmodule

// File: test/tb_ecc_point_scalar_multiply_core.sv
// Self-checking testbench for ecc_point_scalar_multiply_core.
// Depends on ecpsm_pkg and the core; a scoreboard predicts each scalar product
// while tasks drive points and configuration and a receiver drives random output back-pressure.
`timescale 1ns / 100ps

module tb_ecc_point_scalar_multiply_core;
	import ecpsm_pkg::*;

	class ecc_scoreboard;
		typedef struct {
			logic [63:0] x;
			logic [63:0] y;
		} ec_point_t;

		typedef struct {
			logic [15:0] x;
			logic [15:0] y;
			logic        inf;
		} product_t;

		logic [15:0] prime;
		logic [15:0] coeff;
		product_t    products[$];
		int          errors;

		function new();
			prime  = PrimeReset;
			coeff  = CoeffReset;
			errors = 0;
		endfunction

		function logic [63:0] euclid_inv(logic [63:0] v, logic [63:0] m);
			longint r0, r1, r2, t0, t1, t2, q;
			r0 = m;
			r1 = v % m;
			t0 = 0;
			t1 = 1;
			while (r1 != 0) begin
				q  = r0 / r1;
				r2 = r0 - q * r1;
				t2 = t0 - q * t1;
				r0 = r1;
				r1 = r2;
				t0 = t1;
				t1 = t2;
			end
			if (r0 != 1)
				return 0;
			if (t0 < 0)
				t0 += m;
			return t0 % m;
		endfunction

		function logic [63:0] sub_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
			return (a + m - b) % m;
		endfunction

		function ec_point_t point_add(ec_point_t p, ec_point_t q, logic [63:0] m,
				logic [63:0] a);
			ec_point_t r;
			logic [63:0] lam, num;
			r.x = 0;
			r.y = 0;
			if (p.x == 0 && p.y == 0)
				return q;
			if (q.x == 0 && q.y == 0)
				return p;
			if (p.x == q.x) begin
				if (p.y != q.y || p.y == 0)
					return r;
				num = (3 * ((p.x * p.x) % m) + a) % m;
				lam = (num * euclid_inv((2 * p.y) % m, m)) % m;
				r.x = sub_mod((lam * lam) % m, (2 * p.x) % m, m);
			end else begin
				lam = (sub_mod(q.y, p.y, m) * euclid_inv(sub_mod(q.x, p.x, m), m)) % m;
				r.x = sub_mod(sub_mod((lam * lam) % m, p.x, m), q.x, m);
			end
			r.y = sub_mod((lam * sub_mod(p.x, r.x, m)) % m, p.y, m);
			return r;
		endfunction

		function void note_input(logic [15:0] px, logic [15:0] py, logic [15:0] k);
			ec_point_t acc, dbl;
			logic [63:0] m, a;
			logic [15:0] bits;
			product_t res;
			m = prime;
			acc.x = 0;
			acc.y = 0;
			if (m >= 3) begin
				a = coeff % m;
				dbl.x = px % m;
				dbl.y = py % m;
				bits = k;
				while (bits != 0) begin
					if (bits[0])
						acc = point_add(acc, dbl, m, a);
					dbl = point_add(dbl, dbl, m, a);
					bits = bits >> 1;
				end
			end
			res.x   = acc.x[15:0];
			res.y   = acc.y[15:0];
			res.inf = (acc.x == 0 && acc.y == 0);
			products.push_back(res);
		endfunction

		function void check_result(logic [15:0] rx, logic [15:0] ry, logic inf);
			product_t e;
			if (products.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d inf=%0d", $time, rx, ry, inf);
				errors++;
				return;
			end
			e = products.pop_front();
			if (rx !== e.x) begin
				$display("%0t: result_x expected %0d actual %0d", $time, e.x, rx);
				errors++;
			end
			if (ry !== e.y) begin
				$display("%0t: result_y expected %0d actual %0d", $time, e.y, ry);
				errors++;
			end
			if (inf !== e.inf) begin
				$display("%0t: at_infinity expected %0d actual %0d", $time, e.inf, inf);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] point_x;
	logic [15:0] point_y;
	logic [15:0] scalar;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] result_x;
	logic [15:0] result_y;
	logic        at_infinity;

	ecc_scoreboard sb;
	int hold_off_cycles;

	ecc_point_scalar_multiply_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.point_x(point_x),
		.point_y(point_y),
		.scalar(scalar),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_x(result_x),
		.result_y(result_y),
		.at_infinity(at_infinity)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#300_000_000;
		$display("** ecc_point_scalar_multiply_core: FAILED **");
		$finish;
	end

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(20, 200);
	endfunction

	task automatic write_reg(logic idx, logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		if (idx == CfgPrime)
			sb.prime = value;
		else
			sb.coeff = value;
	endtask

	task automatic send_point(logic [15:0] px, logic [15:0] py, logic [15:0] k);
		int gap;
		in_valid <= 1'b1;
		point_x  <= px;
		point_y  <= py;
		scalar   <= k;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_input(px, py, k);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.products.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic send_random_point();
		logic [15:0] px, py, k;
		int r, nbits;
		r = $urandom_range(0, 99);
		if (sb.prime >= 3 && r < 85) begin
			px = 16'($urandom_range(0, sb.prime - 1));
			py = 16'($urandom_range(0, sb.prime - 1));
		end else if (r < 95) begin
			px = 16'($urandom);
			py = 16'($urandom);
		end else begin
			px = (r < 98) ? 16'($urandom) : 16'd0;
			py = 16'd0;
		end
		nbits = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 16);
		k = 16'($urandom);
		k = k & 16'((17'h1 << nbits) - 17'h1);
		if ($urandom_range(0, 19) == 0)
			k = 16'd0;
		send_point(px, py, k);
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_result(result_x, result_y, at_infinity);
	end

	initial begin : receiver
		int left;
		left = 0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				out_stall <= 1'b1;
				hold_off_cycles--;
			end else if (left > 0) begin
				out_stall <= 1'b1;
				left--;
			end else begin
				left = pick_gap();
				out_stall <= (left > 0);
				if (left > 0)
					left--;
			end
		end
	end

	logic [15:0] primes[7] = '{16'd65521, 16'd3, 16'd2, 16'd97, 16'd221, 16'd65535, 16'd0};
	logic [15:0] coeffs[7] = '{16'd0, 16'd65535, 16'd5, 16'd2, 16'd7, 16'd65535, 16'd1};

	initial begin : sender
		sb = new();
		hold_off_cycles = 0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CfgPrime;
		cfg_data  = '0;
		in_valid  = 1'b0;
		point_x   = '0;
		point_y   = '0;
		scalar    = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (5) @(posedge clk);

		// hold the output while further jobs wait behind it
		hold_off_cycles = 20000;
		send_point(16'd5, 16'd7, 16'd1);
		send_point(16'd5, 16'd7, 16'd0);
		send_point(16'd0, 16'd0, 16'd3);
		send_point(16'd0, 16'd0, 16'hffff);
		send_point(16'd100, 16'd0, 16'd2);
		send_point(16'd100, 16'd0, 16'd1);
		send_point(16'd17, 16'd300, 16'd2);
		send_point(16'd17, 16'd300, 16'd3);
		send_point(16'd1222, 16'd1222, 16'd5);
		send_point(16'hffff, 16'hffff, 16'd7);
		send_point(16'd1223, 16'd1223, 16'd4);
		send_point(16'd1223, 16'd9, 16'd6);
		send_point(16'd42, 16'd611, 16'hffff);
		send_point(16'd1, 16'd1, 16'h8000);
		send_point(16'h5555, 16'haaaa, 16'haaaa);
		send_point(16'haaaa, 16'h5555, 16'h5555);
		send_point(16'd0, 16'd1, 16'd9);
		send_point(16'd3, 16'd0, 16'd4);
		repeat (40) send_random_point();
		drain();

		for (int p = 0; p < 7; p++) begin
			write_reg(CfgPrime, primes[p]);
			write_reg(CfgCoeff, coeffs[p]);
			cfg_we <= 1'b0;
			repeat (16) send_random_point();
			drain();
		end

		if (sb.errors == 0)
			$display("** ecc_point_scalar_multiply_core: PASSED **");
		else
			$display("** ecc_point_scalar_multiply_core: FAILED **");
		$finish;
	end
endmodule
